FILE: src/ar2pcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AR(2) prediction change detector - shared package
// Field widths, register indexes, defaults, result codes and payload types.
// ----------------------------------------------------------------------------
package ar2pcd_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_HALF_WINDOW_DEF = 15;
	localparam int SAMPLE_BITS_DEF     = 16;

	// Field widths fixed by the interface
	localparam int SAMPLE_W   = 15;
	localparam int COEF_W     = 16;
	localparam int AVG_W      = 18;
	localparam int HALF_W     = 4;
	localparam int INDEX_W    = 16;
	localparam int EVENT_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	// Fixed-point details: Q.28 products rounded half up to Q.14
	localparam int FRAC_BITS  = 14;
	localparam int ROUND_HALF = 8192;
	localparam int SQ_IN_W    = 16;
	localparam int DIV_CNT_W  = $clog2(AVG_W);

	localparam logic [AVG_W-1:0]   AVG_MAX   = '1;
	localparam logic [INDEX_W-1:0] COUNT_MAX = '1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AR_COEF   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIN  = 2'd2;

	// Register reset values
	localparam logic signed [COEF_W-1:0] AR_COEF_RST   = -16'sd26510;
	localparam logic [AVG_W-1:0]         THRESHOLD_RST = 18'd492;
	localparam logic [HALF_W-1:0]        HALF_WIN_RST  = 4'd5;

	// Detector event codes
	localparam logic [EVENT_W-1:0] EVT_NONE = 2'd0;
	localparam logic [EVENT_W-1:0] EVT_FALL = 2'd1;
	localparam logic [EVENT_W-1:0] EVT_RISE = 2'd2;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       record_start;
	} in_item_t;

	typedef struct packed {
		logic                average_valid;
		logic [INDEX_W-1:0]  centre_index;
		logic [AVG_W-1:0]    window_average;
		logic [EVENT_W-1:0]  detect_event;
	} out_item_t;

endpackage

FILE: src/ar2pcd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AR(2) prediction change detector - stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface ar2pcd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
	modport monitor (input valid, input payload, input ready);
endinterface

FILE: src/ar2pcd_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AR(2) prediction change detector - shared arithmetic unit
// One adder/subtractor and one signed multiplier, selected per cycle.
// ----------------------------------------------------------------------------
module ar2pcd_alu #(
	parameter int DW   = 36,
	parameter int MA_W = 17,
	parameter int MB_W = 17
) (
	input  ar2pcd_pkg::alu_op_t   op,
	input  logic signed [DW-1:0]  a,
	input  logic signed [DW-1:0]  b,
	output logic signed [DW-1:0]  res
);
	import ar2pcd_pkg::*;

	logic signed [MA_W-1:0]      ma;
	logic signed [MB_W-1:0]      mb;
	logic signed [MA_W+MB_W-1:0] prod;

	// multiplier sees only the narrow low slices of the operands
	assign ma   = a[MA_W-1:0];
	assign mb   = b[MB_W-1:0];
	assign prod = ma * mb;

	always_comb begin
		case (op)
			ALU_ADD: res = a + b;
			ALU_SUB: res = a - b;
			ALU_MUL: res = DW'(prod);
			default: res = '0;
		endcase
	end

endmodule

FILE: src/ar2pcd_window_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AR(2) prediction change detector - error window memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ar2pcd_window_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/ar2_prediction_change_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AR(2) prediction change detector - top level
// Predicts each sample from the two before it, squares the prediction error,
// averages it over a centred window and flags the first fall below and the
// next rise above a threshold.
// ----------------------------------------------------------------------------
// Usage:
//  - samples: valid/ready sink of {sample, record_start}. record_start marks
//    index zero of a record and clears history, sample count and detector.
//  - results: valid/ready source, one result per input transfer:
//    {average_valid, centre_index, window_average, detect_event}. Without a
//    full window all four fields are zero.
//  - cfg_write/cfg_index/cfg_data: register writes (coefficient, threshold,
//    half window), taken at any edge with cfg_write high; write while idle.
//  - One item at a time. Each item runs through a sequencer that drives a
//    single shared add/subtract/multiply unit: prediction and squaring, a
//    window write, window summation (2h memory reads, one per cycle, then
//    the last add and a hand-off; no reads when h is zero), a restoring
//    division and a result step (h = half window). Without a full window
//    the summation and division are skipped, and the first two samples of
//    a record also skip prediction and squaring. The result enters the
//    output register at the same edge at which ready returns.
//  - If results is stalled, the finished item waits in the sequencer until
//    the output register frees; samples.ready stays low meanwhile.
//  - Reset clears registers to defaults, history and detector; the window
//    memory needs no clearing since only errors of the current record are read.
// ----------------------------------------------------------------------------
module ar2_prediction_change_detector #(
	parameter int MAX_HALF_WINDOW = ar2pcd_pkg::MAX_HALF_WINDOW_DEF,
	parameter int SAMPLE_BITS     = ar2pcd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [ar2pcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ar2pcd_pkg::CFG_DATA_W-1:0] cfg_data,
	ar2pcd_stream_if.sink                     samples,
	ar2pcd_stream_if.source                   results
);
	import ar2pcd_pkg::*;

	// Derived sizes
	localparam int WIN_DEPTH = 2 * MAX_HALF_WINDOW + 2;
	localparam int MAW       = $clog2(WIN_DEPTH);
	localparam int H_W       = $clog2(MAX_HALF_WINDOW + 1);
	localparam int LEN_W     = H_W + 1;
	localparam int SUM_W     = AVG_W + LEN_W;
	localparam int MA_W      = (SAMPLE_BITS > SQ_IN_W + 1) ? SAMPLE_BITS : SQ_IN_W + 1;
	localparam int MB_W      = SQ_IN_W + 1;
	localparam int DW        = ((SAMPLE_BITS + COEF_W > 2 * MB_W) ?
	                            SAMPLE_BITS + COEF_W : 2 * MB_W) + 2;
	localparam int X_HI      = (1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam int X_LO      = -X_HI - 1;

	// Sequencer states
	typedef enum logic [11:0] {
		ST_IDLE  = 12'b0000_0000_0001,
		ST_MUL   = 12'b0000_0000_0010,
		ST_RND   = 12'b0000_0000_0100,
		ST_ADDX  = 12'b0000_0000_1000,
		ST_ADDP  = 12'b0000_0001_0000,
		ST_ABS   = 12'b0000_0010_0000,
		ST_SQR   = 12'b0000_0100_0000,
		ST_SQRND = 12'b0000_1000_0000,
		ST_WRITE = 12'b0001_0000_0000,
		ST_SUM   = 12'b0010_0000_0000,
		ST_DIV   = 12'b0100_0000_0000,
		ST_DONE  = 12'b1000_0000_0000
	} seq_state_t;

	// Detector phases
	typedef enum logic [2:0] {
		PH_WAIT_FALL = 3'b001,
		PH_WAIT_RISE = 3'b010,
		PH_FINISHED  = 3'b100
	} phase_t;

	// Configuration registers
	logic signed [COEF_W-1:0] coef_q;
	logic [AVG_W-1:0]         thr_q;
	logic [HALF_W-1:0]        hw_q;

	// Sequencer and record state
	seq_state_t                   seq_q;
	phase_t                       phase_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS-1:0] pprev_q;
	logic [INDEX_W-1:0]           cnt_q;

	// Working registers of the current item
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] p1_q;
	logic signed [SAMPLE_BITS-1:0] p2_q;
	logic [INDEX_W-1:0]           idx_q;
	logic signed [DW-1:0]         t_q;
	logic [AVG_W-1:0]             err_q;
	logic [SUM_W-1:0]             acc_q;
	logic                         avg_ok_q;
	logic [MAW-1:0]               wp_q;
	logic [MAW-1:0]               rp_q;
	logic [LEN_W-1:0]             issue_q;
	logic                         rd_vld_q;
	logic [LEN_W-1:0]             rem_q;
	logic [AVG_W-1:0]             quo_q;
	logic [DIV_CNT_W-1:0]         div_cnt_q;

	// Output register
	out_item_t out_q;
	logic      out_valid_q;

	// Combinational
	logic                          in_xfer;
	logic                          out_free;
	logic                          start;
	logic signed [31:0]            xs;
	logic signed [SAMPLE_BITS-1:0] xc;
	logic [H_W-1:0]                h_eff;
	logic [LEN_W-1:0]              len;
	logic                          win_ok;
	alu_op_t                       alu_op;
	logic signed [DW-1:0]          alu_a;
	logic signed [DW-1:0]          alu_b;
	logic signed [DW-1:0]          alu_res;
	logic signed [DW-1:0]          abs_e;
	logic                          rd_en;
	logic [AVG_W-1:0]              rd_data;
	logic                          div_neg;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= AR_COEF_RST;
			thr_q  <= THRESHOLD_RST;
			hw_q   <= HALF_WIN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_AR_COEF:   coef_q <= $signed(cfg_data[COEF_W-1:0]);
				REG_THRESHOLD: thr_q  <= cfg_data[AVG_W-1:0];
				REG_HALF_WIN:  hw_q   <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the half window to what the window memory can hold
	always_comb begin
		if (32'(hw_q) > MAX_HALF_WINDOW) begin
			h_eff = H_W'(MAX_HALF_WINDOW);
		end else begin
			h_eff = H_W'(hw_q);
		end
	end

	assign len    = {h_eff, 1'b1};
	assign win_ok = ({1'b0, idx_q} + (INDEX_W + 1)'(1)) >= (INDEX_W + 1)'(len);

	// ---------------------------------------------------------------- input
	assign samples.ready = (seq_q == ST_IDLE);
	assign in_xfer       = samples.valid && samples.ready;
	assign start         = samples.payload.record_start;

	// Clamp the sample into the history range
	assign xs = 32'($signed(samples.payload.sample));
	always_comb begin
		if (xs > X_HI) begin
			xc = SAMPLE_BITS'(X_HI);
		end else if (xs < X_LO) begin
			xc = SAMPLE_BITS'(X_LO);
		end else begin
			xc = SAMPLE_BITS'(xs);
		end
	end

	// ---------------------------------------------------------------- shared unit
	// Steer operands according to the sequencer step
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		case (seq_q)
			ST_MUL: begin
				alu_op = ALU_MUL;
				alu_a  = DW'(p1_q);
				alu_b  = DW'(coef_q);
			end
			ST_RND, ST_SQRND: begin
				alu_a = t_q;
				alu_b = DW'(ROUND_HALF);
			end
			ST_ADDX: begin
				alu_a = t_q;
				alu_b = DW'(x_q);
			end
			ST_ADDP: begin
				alu_a = t_q;
				alu_b = DW'(p2_q);
			end
			ST_ABS: begin
				alu_op = ALU_SUB;
				alu_b  = t_q;
			end
			ST_SQR: begin
				alu_op = ALU_MUL;
				alu_a  = t_q;
				alu_b  = t_q;
			end
			ST_SUM: begin
				alu_a = DW'(acc_q);
				alu_b = DW'(rd_data);
			end
			ST_DIV: begin
				alu_op = ALU_SUB;
				alu_a  = DW'({rem_q, quo_q[AVG_W-1]});
				alu_b  = DW'(len);
			end
			default: ;
		endcase
	end

	ar2pcd_alu #(
		.DW   (DW),
		.MA_W (MA_W),
		.MB_W (MB_W)
	) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign abs_e   = t_q[DW-1] ? alu_res : t_q;
	assign div_neg = alu_res[DW-1];

	// ---------------------------------------------------------------- window memory
	assign rd_en = (seq_q == ST_SUM) && (issue_q != '0);

	ar2pcd_window_ram #(
		.DEPTH (WIN_DEPTH),
		.AW    (MAW),
		.DW    (AVG_W)
	) u_window_ram (
		.clk   (clk),
		.we    (seq_q == ST_WRITE),
		.waddr (wp_q),
		.wdata (err_q),
		.re    (rd_en),
		.raddr (rp_q),
		.rdata (rd_data)
	);

	// ---------------------------------------------------------------- output
	assign out_free        = !out_valid_q || results.ready;
	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	// ---------------------------------------------------------------- control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= ST_IDLE;
			phase_q     <= PH_WAIT_FALL;
			prev_q      <= '0;
			pprev_q     <= '0;
			cnt_q       <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the held result once the receiver takes it; the result
			// step loads the next one on its own
			if (out_valid_q && results.ready && seq_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				ST_IDLE: begin
					if (in_xfer) begin
						pprev_q <= start ? '0 : prev_q;
						prev_q  <= xc;
						if (start) begin
							cnt_q   <= INDEX_W'(1);
							phase_q <= PH_WAIT_FALL;
						end else if (cnt_q != COUNT_MAX) begin
							cnt_q <= cnt_q + INDEX_W'(1);
						end
						// first two samples of a record carry no error
						if (start || cnt_q < INDEX_W'(2)) begin
							seq_q <= ST_WRITE;
						end else begin
							seq_q <= ST_MUL;
						end
					end
				end
				ST_MUL:   seq_q <= ST_RND;
				ST_RND:   seq_q <= ST_ADDX;
				ST_ADDX:  seq_q <= ST_ADDP;
				ST_ADDP:  seq_q <= ST_ABS;
				ST_ABS: begin
					if (|abs_e[DW-1:SQ_IN_W]) begin
						seq_q <= ST_WRITE;
					end else begin
						seq_q <= ST_SQR;
					end
				end
				ST_SQR:   seq_q <= ST_SQRND;
				ST_SQRND: seq_q <= ST_WRITE;
				ST_WRITE: begin
					wp_q  <= (wp_q == MAW'(WIN_DEPTH - 1)) ? '0 : wp_q + MAW'(1);
					seq_q <= win_ok ? ST_SUM : ST_DONE;
				end
				ST_SUM: begin
					if (issue_q == '0 && !rd_vld_q) begin
						seq_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						seq_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						seq_q       <= ST_IDLE;
						if (avg_ok_q) begin
							if (phase_q == PH_WAIT_FALL && quo_q < thr_q) begin
								phase_q <= PH_WAIT_RISE;
							end else if (phase_q == PH_WAIT_RISE && quo_q > thr_q) begin
								phase_q <= PH_FINISHED;
							end
						end
					end
				end
				default: seq_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (seq_q)
			ST_IDLE: begin
				if (in_xfer) begin
					x_q   <= xc;
					p1_q  <= start ? '0 : prev_q;
					p2_q  <= start ? '0 : pprev_q;
					idx_q <= start ? '0 : cnt_q;
					err_q <= '0;
				end
			end
			ST_MUL, ST_ADDX, ST_ADDP, ST_SQR: t_q <= alu_res;
			// round half up: add half an LSB, then floor by arithmetic shift
			ST_RND: t_q <= alu_res >>> FRAC_BITS;
			ST_ABS: begin
				if (|abs_e[DW-1:SQ_IN_W]) begin
					err_q <= AVG_MAX;
				end else begin
					t_q <= abs_e;
				end
			end
			ST_SQRND: err_q <= alu_res[FRAC_BITS+AVG_W-1:FRAC_BITS];
			ST_WRITE: begin
				acc_q    <= SUM_W'(err_q);
				avg_ok_q <= win_ok;
				rp_q     <= (wp_q == '0) ? MAW'(WIN_DEPTH - 1) : wp_q - MAW'(1);
				issue_q  <= len - LEN_W'(1);
				rd_vld_q <= 1'b0;
			end
			ST_SUM: begin
				// issue one read per cycle, add the data in the cycle after its read
				if (rd_en) begin
					rp_q    <= (rp_q == '0) ? MAW'(WIN_DEPTH - 1) : rp_q - MAW'(1);
					issue_q <= issue_q - LEN_W'(1);
				end
				rd_vld_q <= rd_en;
				if (rd_vld_q) begin
					acc_q <= alu_res[SUM_W-1:0];
				end
				if (issue_q == '0 && !rd_vld_q) begin
					// quotient fits the average width, so the high part is below len
					rem_q     <= acc_q[SUM_W-1:AVG_W];
					quo_q     <= acc_q[AVG_W-1:0];
					div_cnt_q <= DIV_CNT_W'(AVG_W - 1);
				end
			end
			ST_DIV: begin
				if (div_neg) begin
					rem_q <= {rem_q[LEN_W-2:0], quo_q[AVG_W-1]};
				end else begin
					rem_q <= alu_res[LEN_W-1:0];
				end
				quo_q     <= {quo_q[AVG_W-2:0], !div_neg};
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					if (avg_ok_q) begin
						out_q.average_valid  <= 1'b1;
						out_q.centre_index   <= idx_q - INDEX_W'(h_eff);
						out_q.window_average <= quo_q;
						if (phase_q == PH_WAIT_FALL && quo_q < thr_q) begin
							out_q.detect_event <= EVT_FALL;
						end else if (phase_q == PH_WAIT_RISE && quo_q > thr_q) begin
							out_q.detect_event <= EVT_RISE;
						end else begin
							out_q.detect_event <= EVT_NONE;
						end
					end else begin
						out_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: src/ar2pcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AR(2) prediction change detector - port checker
// Watches the channels of the top level and flags illegal behavior.
// ----------------------------------------------------------------------------
module ar2pcd_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  ar2pcd_pkg::out_item_t out_item
);
	import ar2pcd_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("stalled result changed");

	// one item in flight: ready drops right after an input transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	a_event_needs_avg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.detect_event != EVT_NONE
		|-> out_item.average_valid)
		else $error("event without a full-window average");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.average_valid
		|-> out_item.centre_index == '0 && out_item.window_average == '0
		&& out_item.detect_event == EVT_NONE)
		else $error("partial window result not cleared");

endmodule

bind ar2_prediction_change_detector ar2pcd_checker u_ar2pcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_item  (results.payload)
);
